// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is held
`define ASSERT_CLK(label, clk_sig, rst_n, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) (prop)) \
	else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk_sig, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

// File: rtl/alis_pkg.sv
// ----------------------------------------------------------------------------
// alis_pkg
// types and codes shared by the array list blocks
// ----------------------------------------------------------------------------
package alis_pkg;

	localparam int DATA_W   = 32;
	localparam int ACTION_W = 3;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 3;
	localparam int FOUND_W  = 5;
	localparam int LENGTH_W = 6;

	localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SEARCH   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DEL_LAST = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DEL_AT   = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// per-cell control for one transaction
	typedef struct packed {
		logic load_value;
		logic take_left;
		logic take_right;
		logic occupied;
	} cell_ctrl_t;

endpackage

// File: rtl/array_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_search
// ordered list of up to CAPACITY signed 32-bit entries held in a row of cells.
// input transaction: action, value, position on in_valid/in_ready.
// output transaction: status, found_index, length on out_valid/out_ready.
// every transaction returns exactly one result, through the middle stage and the output register.
// one transaction per cycle while the receiver does not stall: all cells shift and compare in parallel,
// and the lowest-match encoder sits in the second stage.
// a stalled receiver holds the output register; the middle stage then fills
// and in_ready drops until out_ready returns.
// reset empties the list (length 0); entry contents are not cleared.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search
	import alis_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] action,
	input  logic signed [DATA_W-1:0] value,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [FOUND_W-1:0]  found_index,
	output logic [LENGTH_W-1:0] length
);

	`include "assert_macros.svh"

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int FW   = (IW > FOUND_W) ? IW : FOUND_W;
	localparam int LW   = (CW > LENGTH_W) ? CW : LENGTH_W;

	logic [CW-1:0]   count_q;
	logic            valid_s1;
	status_t         status_s1;
	logic            search_s1;
	logic            out_valid_q;
	status_t         status_q;
	logic [FOUND_W-1:0]  found_q;
	logic [LENGTH_W-1:0] length_q;

	logic            accept;
	logic            out_adv;
	logic            s1_adv;
	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] cnt_ext;
	logic            is_full;
	logic            is_empty;
	logic            do_append;
	logic            do_insert;
	logic            do_delete;
	logic            do_dec;
	status_t         status_d;

	logic [DATA_W-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0] match_w;
	cell_ctrl_t        ctrl_w [CAPACITY];
	logic              any_match;
	logic [IW-1:0]     match_idx;
	logic [FW-1:0]     found_ext;
	logic [LW-1:0]     length_ext;

	// handshake
	assign out_adv  = !out_valid_q || out_ready;
	assign s1_adv   = valid_s1 && out_adv;
	assign in_ready = !valid_s1 || out_adv;
	assign accept   = in_valid && in_ready;

	assign pos_ext  = CMPW'(position);
	assign cnt_ext  = CMPW'(count_q);
	assign is_full  = (cnt_ext >= CMPW'(CAPACITY));
	assign is_empty = (count_q == '0);

	// decode action into list edits and a status
	always_comb begin
		do_append = 1'b0;
		do_insert = 1'b0;
		do_delete = 1'b0;
		do_dec    = 1'b0;
		status_d  = ST_OK;
		case (action)
			ACT_APPEND: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					do_append = 1'b1;
				end
			end
			ACT_INSERT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else if (pos_ext > cnt_ext) begin
					status_d = ST_RANGE;
				end else begin
					do_insert = 1'b1;
				end
			end
			ACT_SEARCH: begin
				status_d = ST_NOTFOUND;
			end
			ACT_DEL_LAST: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					do_dec = 1'b1;
				end
			end
			ACT_DEL_AT: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = ST_RANGE;
				end else begin
					do_delete = 1'b1;
					do_dec    = 1'b1;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CMPW-1:0] IDX = CMPW'(i);
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		assign ctrl_w[i].load_value = (do_append && (IDX == cnt_ext)) ||
			(do_insert && (IDX == pos_ext));
		assign ctrl_w[i].take_left  = do_insert && (IDX > pos_ext);
		assign ctrl_w[i].take_right = do_delete && (IDX >= pos_ext);
		assign ctrl_w[i].occupied   = (IDX < cnt_ext);

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = entry_w[i];
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end

		alis_cell u_cell (
			.clk   (clk),
			.en    (accept),
			.ctrl  (ctrl_w[i]),
			.value (value),
			.left  (left_w),
			.right (right_w),
			.entry (entry_w[i]),
			.match (match_w[i])
		);
	end

	alis_find #(
		.N  (CAPACITY),
		.IW (IW)
	) u_find (
		.match (match_w),
		.any   (any_match),
		.idx   (match_idx)
	);

	assign found_ext  = FW'(match_idx);
	assign length_ext = LW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (do_append || do_insert) begin
					count_q <= count_q + CW'(1);
				end else if (do_dec) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			search_s1 <= (action == ACT_SEARCH);
		end
		// count_q already holds this transaction's new length here
		if (s1_adv) begin
			length_q <= length_ext[LENGTH_W-1:0];
			if (search_s1 && any_match) begin
				status_q <= ST_OK;
				found_q  <= found_ext[FOUND_W-1:0];
			end else begin
				status_q <= status_s1;
				found_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign length      = length_q;

	`ASSERT_CLK(a_count_cap, clk, arst_n, CW'(CAPACITY) >= count_q, "count above capacity")
	`ASSERT_IMPL(a_found_ok, clk, arst_n, out_valid_q && (status_q != ST_OK), found_q == '0,
		"found index set without a successful search")
	`ASSERT_CLK(a_full_hold, clk, arst_n,
		(accept && (action == ACT_APPEND) && is_full) |=> $stable(count_q),
		"append on full list changed length")
	`ASSERT_CLK(a_s1_hold, clk, arst_n, (valid_s1 && !out_adv) |=> valid_s1,
		"middle stage dropped a stalled transaction")

endmodule

// File: rtl/alis_cell.sv
// ----------------------------------------------------------------------------
// alis_cell
// one list slot: holds an entry, shifts with its neighbors, flags a match
// ----------------------------------------------------------------------------
module alis_cell
	import alis_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  cell_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] entry,
	output logic              match
);

	logic [DATA_W-1:0] entry_q;
	logic              match_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctrl.load_value) begin
				entry_q <= value;
			end else if (ctrl.take_left) begin
				entry_q <= left;
			end else if (ctrl.take_right) begin
				entry_q <= right;
			end
			// compare against contents before this transaction's update
			match_q <= ctrl.occupied && (entry_q == value);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// File: rtl/alis_find.sv
// ----------------------------------------------------------------------------
// alis_find
// picks the lowest flagged cell and encodes its index
// ----------------------------------------------------------------------------
module alis_find
	import alis_pkg::*;
#(
	parameter int N  = 32,
	parameter int IW = 5
) (
	input  logic [N-1:0]  match,
	output logic          any,
	output logic [IW-1:0] idx
);

	logic [N-1:0] lowest;

	// isolate lowest set bit, then or-encode
	assign lowest = match & (~match + N'(1));
	assign any    = |match;

	always_comb begin
		idx = '0;
		for (int b = 0; b < IW; b++) begin
			for (int i = 0; i < N; i++) begin
				if (((i >> b) & 1) == 1) begin
					idx[b] = idx[b] | lowest[i];
				end
			end
		end
	end

endmodule
